// File: rtl/cell_voltage_balance_monitor_defines.svh
// Assertion macros shared by the cell voltage balance monitor RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef CELL_VOLTAGE_BALANCE_MONITOR_DEFINES_SVH
`define CELL_VOLTAGE_BALANCE_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CVBM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cvbm assertion failed");
`define CVBM_ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("cvbm assertion failed");
`else
`define CVBM_ASSERT(label, clk, rst, prop)
`define CVBM_ASSERT_NEXT(label, clk, rst, trig, prop)
`endif

`endif

// File: rtl/cvbm_pkg.sv
package cvbm_pkg;

   localparam int CELLS_DEFAULT = 10;
   localparam int MAX_CELLS     = 10;
   localparam int GROUP_ONE_CELLS = 4;

   localparam int RAW_W    = 14;
   localparam int GAIN_W   = 5;
   localparam int OFFSET_W = 8;
   localparam int MV_W     = 13;
   localparam int SUM_W    = 17;
   localparam int POS_W    = 4;
   localparam int MASK_W   = 5;

   // Gain in microvolts per LSB is GAIN_BASE plus the trim code.
   localparam int GAIN_BASE = 365;
   localparam int SCALE_W   = 9;
   localparam int PROD_W    = RAW_W + SCALE_W;

   // Division by 1000 is a shift by three followed by a reciprocal multiply
   // by 1/125, exact for every product this block can form.
   localparam int DIVISOR     = 1000;
   localparam int PRE_SHIFT   = 3;
   localparam int DIV_REST    = DIVISOR >> PRE_SHIFT;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + DIV_REST - 1) / DIV_REST;
   localparam int RECIP_W     = 21;
   localparam int DIV_IN_W    = PROD_W - PRE_SHIFT;
   localparam int DIV_PROD_W  = DIV_IN_W + RECIP_W;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_CODE         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_MV         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALANCE_THRESHOLD = 2'd2;

   localparam logic [GAIN_W-1:0]     GAIN_CODE_RESET = 5'd12;
   localparam logic [OFFSET_W-1:0]   OFFSET_RESET    = 8'd0;
   localparam logic [MV_W-1:0]       THRESHOLD_RESET = 13'd50;

   localparam logic [MASK_W-1:0] BAL_BIT0 = 5'h01;
   localparam logic [MASK_W-1:0] BAL_BIT1 = 5'h02;
   localparam logic [MASK_W-1:0] BAL_BIT2 = 5'h04;
   localparam logic [MASK_W-1:0] BAL_BIT3 = 5'h08;
   localparam logic [MASK_W-1:0] BAL_BIT4 = 5'h10;

   typedef struct packed {
      logic [RAW_W-1:0] cell_raw;
      logic             last_cell;
   } cvbm_req_type;

   typedef struct packed {
      logic [MV_W-1:0]   cell_mv;
      logic              scan_done;
      logic [SUM_W-1:0]  pack_mv;
      logic [POS_W-1:0]  highest_cell;
      logic [POS_W-1:0]  lowest_cell;
      logic [MV_W-1:0]   spread_mv;
      logic              balancing;
      logic [MASK_W-1:0] group_one_mask;
      logic [MASK_W-1:0] group_two_mask;
   } cvbm_rsp_type;

   typedef struct packed {
      logic [MV_W-1:0] cell_mv;
      logic            last_cell;
   } cvbm_mid_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_code;
      logic [OFFSET_W-1:0] offset_mv;
      logic [MV_W-1:0]     balance_threshold;
   } cvbm_cfg_type;

   function automatic logic [MV_W-1:0] div_by_1000(input logic [PROD_W-1:0] prod);
      logic [DIV_IN_W-1:0]   x;
      logic [DIV_PROD_W-1:0] p;
      x = prod[PROD_W-1:PRE_SHIFT];
      p = DIV_PROD_W'(x) * DIV_PROD_W'(RECIP);
      return p[RECIP_SHIFT +: MV_W];
   endfunction

   // Balance bit of a cell within its group's mask.
   function automatic logic [MASK_W-1:0] bal_bits(input logic [POS_W-1:0] cell_pos);
      logic [MASK_W-1:0] bits;
      unique case (cell_pos)
         4'd0:    bits = BAL_BIT0;
         4'd1:    bits = BAL_BIT1;
         4'd2:    bits = BAL_BIT2;
         4'd3:    bits = BAL_BIT4;
         4'd4:    bits = BAL_BIT0;
         4'd5:    bits = BAL_BIT1;
         4'd6:    bits = BAL_BIT4;
         4'd7:    bits = BAL_BIT2;
         4'd8:    bits = BAL_BIT3;
         4'd9:    bits = BAL_BIT4;
         default: bits = '0;
      endcase
      return bits;
   endfunction

endpackage

// File: rtl/cell_voltage_balance_monitor.sv
// Cell voltage balance monitor. Each request carries one raw 14-bit ADC code,
// cells in scan order; the block returns one result per request, in order, with
// the reading in millivolts (raw * (365 + gain_code) / 1000 + offset_mv) and, on
// the result that closes a scan (last_cell set or the CELLS-th reading), the pack
// sum, highest and lowest cell, spread and the updated balance masks. One request
// is taken every clock cycle while req_full is low. The gain product is registered
// as the request is taken; the reciprocal divide by 1000 and offset add work on
// that registered product, and their result is registered again before it is
// pushed into the middle queue. The scan update unit, which handles one reading
// per cycle while the middle queue holds one and the response queue has room,
// writes each result into the response queue. Queues between the converter and
// the scan unit, and on the response side, absorb stalls of either side.
// Write the configuration registers only while no request is in flight.
module cell_voltage_balance_monitor #(
   parameter int CELLS = cvbm_pkg::CELLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  cvbm_pkg::cvbm_req_type               req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output cvbm_pkg::cvbm_rsp_type               rsp_data,
   input  logic                                csr_write_en,
   input  logic [cvbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cvbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cvbm_pkg::*;

   cvbm_cfg_type cfg_ff, cfg_in;
   logic         mid_push, mid_full, mid_pop, mid_empty;
   cvbm_mid_type mid_wdata, mid_rdata;
   logic         out_push, out_full;
   cvbm_rsp_type out_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAIN_CODE:         cfg_in.gain_code         = csr_wdata[GAIN_W-1:0];
            CSR_OFFSET_MV:         cfg_in.offset_mv         = csr_wdata[OFFSET_W-1:0];
            CSR_BALANCE_THRESHOLD: cfg_in.balance_threshold = csr_wdata[MV_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_code         <= GAIN_CODE_RESET;
         cfg_ff.offset_mv         <= OFFSET_RESET;
         cfg_ff.balance_threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cvbm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .mid_push (mid_push),
      .mid_full (mid_full),
      .mid_data (mid_wdata)
   );

   cvbm_fifo #(
      .WIDTH ($bits(cvbm_mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .full  (mid_full),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .empty (mid_empty),
      .rdata (mid_rdata)
   );

   cvbm_back #(
      .CELLS (CELLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_data  (mid_rdata),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   cvbm_fifo #(
      .WIDTH ($bits(cvbm_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (out_item),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_data)
   );

endmodule

// File: rtl/cvbm_fifo.sv
`include "cell_voltage_balance_monitor_defines.svh"

module cvbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr, rd;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign wr    = push && !full;
   assign rd    = pop && !empty;
   assign rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   `CVBM_ASSERT(a_count_bounded, clock, reset, count_ff <= FULL_CNT)
   `CVBM_ASSERT_NEXT(a_count_up, clock, reset, wr && !rd, count_ff == $past(count_ff) + 1'b1)
   `CVBM_ASSERT_NEXT(a_count_down, clock, reset, rd && !wr, count_ff == $past(count_ff) - 1'b1)

endmodule

// File: rtl/cvbm_front.sv
module cvbm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cvbm_pkg::cvbm_cfg_type cfg,
   input  logic                  req_push,
   output logic                  req_full,
   input  cvbm_pkg::cvbm_req_type req_data,
   output logic                  mid_push,
   input  logic                  mid_full,
   output cvbm_pkg::cvbm_mid_type mid_data
);
   import cvbm_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic                s1_last_ff;
   logic                s2_valid_ff, s2_valid_in;
   cvbm_mid_type        s2_item_ff, s2_item_in;
   logic                s1_ready, s2_ready, accept;
   logic [SCALE_W-1:0]  scale;
   logic [MV_W:0]       mv_sum;

   assign s2_ready = !s2_valid_ff || !mid_full;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign accept   = req_push && s1_ready;
   assign req_full = !s1_ready;

   assign mid_push = s2_valid_ff;
   assign mid_data = s2_item_ff;

   always_comb begin
      scale       = SCALE_W'(GAIN_BASE) + SCALE_W'(cfg.gain_code);
      s1_prod_in  = PROD_W'(req_data.cell_raw) * PROD_W'(scale);
      s1_valid_in = s1_ready ? req_push : s1_valid_ff;

      mv_sum                = (MV_W + 1)'(div_by_1000(s1_prod_ff)) + (MV_W + 1)'(cfg.offset_mv);
      s2_item_in.cell_mv    = mv_sum[MV_W-1:0];
      s2_item_in.last_cell  = s1_last_ff;
      s2_valid_in           = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= req_data.last_cell;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

endmodule

// File: rtl/cvbm_back.sv
`include "cell_voltage_balance_monitor_defines.svh"

module cvbm_back #(
   parameter int CELLS = cvbm_pkg::CELLS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cvbm_pkg::cvbm_cfg_type  cfg,
   input  logic                   mid_empty,
   output logic                   mid_pop,
   input  cvbm_pkg::cvbm_mid_type  mid_data,
   input  logic                   out_full,
   output logic                   out_push,
   output cvbm_pkg::cvbm_rsp_type  out_item
);
   import cvbm_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(CELLS - 1);
   localparam logic [POS_W-1:0] GROUP_SPLIT = POS_W'(GROUP_ONE_CELLS);

   logic [POS_W-1:0]  cell_index_ff, cell_index_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [MV_W-1:0]   max_ff, max_in;
   logic [MV_W-1:0]   min_ff, min_in;
   logic [POS_W-1:0]  max_pos_ff, max_pos_in;
   logic [POS_W-1:0]  min_pos_ff, min_pos_in;
   logic [MASK_W-1:0] mask_one_ff, mask_one_in;
   logic [MASK_W-1:0] mask_two_ff, mask_two_in;
   logic              fire, done, bal;
   logic [MV_W-1:0]   spread;

   assign fire     = !mid_empty && !out_full;
   assign mid_pop  = fire;
   assign out_push = fire;

   always_comb begin
      max_in     = max_ff;
      min_in     = min_ff;
      max_pos_in = max_pos_ff;
      min_pos_in = min_pos_ff;
      if (cell_index_ff == '0) begin
         max_in     = mid_data.cell_mv;
         min_in     = mid_data.cell_mv;
         max_pos_in = '0;
         min_pos_in = '0;
      end else begin
         if (mid_data.cell_mv > max_ff) begin
            max_in     = mid_data.cell_mv;
            max_pos_in = cell_index_ff;
         end
         if (mid_data.cell_mv < min_ff) begin
            min_in     = mid_data.cell_mv;
            min_pos_in = cell_index_ff;
         end
      end
      sum_in = sum_ff + SUM_W'(mid_data.cell_mv);
      done   = mid_data.last_cell || (cell_index_ff == LAST_POS);
      spread = max_in - min_in;
      bal    = spread > cfg.balance_threshold;

      mask_one_in = mask_one_ff;
      mask_two_in = mask_two_ff;
      if (done) begin
         if (bal) begin
            if (max_pos_in < GROUP_SPLIT) begin
               mask_one_in = bal_bits(max_pos_in);
            end else begin
               mask_two_in = bal_bits(max_pos_in);
            end
         end else begin
            mask_one_in = '0;
            mask_two_in = '0;
         end
      end
      cell_index_in = done ? '0 : cell_index_ff + 1'b1;

      out_item                = '0;
      out_item.cell_mv        = mid_data.cell_mv;
      out_item.group_one_mask = mask_one_in;
      out_item.group_two_mask = mask_two_in;
      if (done) begin
         out_item.scan_done    = 1'b1;
         out_item.pack_mv      = sum_in;
         out_item.highest_cell = max_pos_in;
         out_item.lowest_cell  = min_pos_in;
         out_item.spread_mv    = spread;
         out_item.balancing    = bal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_index_ff <= '0;
         sum_ff        <= '0;
         max_ff        <= '0;
         min_ff        <= '0;
         max_pos_ff    <= '0;
         min_pos_ff    <= '0;
         mask_one_ff   <= '0;
         mask_two_ff   <= '0;
      end else if (fire) begin
         cell_index_ff <= cell_index_in;
         mask_one_ff   <= mask_one_in;
         mask_two_ff   <= mask_two_in;
         if (done) begin
            sum_ff     <= '0;
            max_ff     <= '0;
            min_ff     <= '0;
            max_pos_ff <= '0;
            min_pos_ff <= '0;
         end else begin
            sum_ff     <= sum_in;
            max_ff     <= max_in;
            min_ff     <= min_in;
            max_pos_ff <= max_pos_in;
            min_pos_ff <= min_pos_in;
         end
      end
   end

   `CVBM_ASSERT(a_index_in_scan, clock, reset, cell_index_ff <= LAST_POS)
   `CVBM_ASSERT_NEXT(a_restart_after_scan, clock, reset, fire && done, cell_index_ff == '0)
   `CVBM_ASSERT(a_balance_over_threshold, clock, reset, out_push && out_item.balancing |-> out_item.spread_mv > cfg.balance_threshold)
   `CVBM_ASSERT(a_masks_cleared, clock, reset, out_push && out_item.scan_done && !out_item.balancing |-> out_item.group_one_mask == '0 && out_item.group_two_mask == '0)

endmodule
